/* rtl/wsdf_pkg.sv */
// ----------------------------------------------------------------------------
// wsdf_pkg
// shared types and codes of the websocket frame deframer
// ----------------------------------------------------------------------------
`default_nettype none

package wsdf_pkg;

  // parser phase
  typedef enum logic [2:0] {
    PH_HDR0    = 3'd0,
    PH_HDR1    = 3'd1,
    PH_EXT     = 3'd2,
    PH_MASK    = 3'd3,
    PH_PAYLOAD = 3'd4,
    PH_CLOSED  = 3'd5
  } phase_e;

  // result kinds
  typedef enum logic [2:0] {
    KIND_MSG        = 3'd0,
    KIND_EMPTY_END  = 3'd1,
    KIND_PONG       = 3'd2,
    KIND_EMPTY_PONG = 3'd3,
    KIND_DISCARD    = 3'd4,
    KIND_CLOSE      = 3'd5,
    KIND_OVERSIZE   = 3'd6
  } kind_e;

  // frame opcodes
  localparam logic [3:0] OP_CONT   = 4'h0;
  localparam logic [3:0] OP_BINARY = 4'h2;
  localparam logic [3:0] OP_CLOSE  = 4'h8;
  localparam logic [3:0] OP_PING   = 4'h9;

  localparam logic [6:0] LEN_EXT16 = 7'd126;
  localparam logic [6:0] LEN_EXT64 = 7'd127;

  localparam logic [15:0] MAX_FRAME_LEN_RST = 16'd8192;

  typedef struct packed {
    kind_e       kind;
    logic [7:0]  data;
    logic        last;
    logic        dropped_before;
  } result_t;

endpackage

`default_nettype wire

/* rtl/wsdf_parser.sv */
// ----------------------------------------------------------------------------
// wsdf_parser
// header parser and payload unmasking, one stream byte per cycle while step_i is high
// ----------------------------------------------------------------------------
`default_nettype none

module wsdf_parser import wsdf_pkg::*; (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire logic        step_i,
  input  wire logic [7:0]  byte_i,
  input  wire logic [15:0] max_frame_len_i,
  output logic             res_valid_o,
  output result_t          res_o
);

  phase_e      phase_q, phase_d;
  logic [2:0]  hbc_q, hbc_d;
  logic        final_q, final_d;
  logic [3:0]  op_q, op_d;
  logic        masked_q, masked_d;
  logic        long_q, long_d;
  logic [31:0] flen_q, flen_d;
  logic [15:0] idx_q, idx_d;
  logic [31:0] mkey_q, mkey_d;
  logic        open_q, open_d;
  logic        drop_q, drop_d;

  logic [6:0]  len7;
  logic        ext_form;
  logic        len_done;
  logic [31:0] new_len;
  logic        oversize;
  logic        masked_eff;
  logic        mask_done;
  logic        start_pl;
  logic [31:0] start_len;
  logic        start_zero;
  logic        is_end;
  phase_e      start_next;
  phase_e      len_next;
  logic        drop_set;
  logic        open_eff;
  logic [7:0]  key_byte;

  // empty binary ends on fin; empty continuation also needs an open message
  function automatic logic fin_ok(input logic [3:0] op, input logic fin, input logic opn);
    fin_ok = fin && ((op == OP_BINARY) || opn);
  endfunction

  // decode of the current byte against the phase
  always_comb begin
    len7       = byte_i[6:0];
    ext_form   = (len7 == LEN_EXT16) || (len7 == LEN_EXT64);
    len_done   = ((phase_q == PH_HDR1) && !ext_form) ||
                 ((phase_q == PH_EXT) && (hbc_q == (long_q ? 3'd7 : 3'd1)));
    new_len    = (phase_q == PH_HDR1) ? (ext_form ? 32'd0 : {25'd0, len7})
                                      : {flen_q[23:0], byte_i};
    oversize   = len_done && (new_len > {16'd0, max_frame_len_i});
    masked_eff = (phase_q == PH_HDR1) ? byte_i[7] : masked_q;
    mask_done  = (phase_q == PH_MASK) && (hbc_q >= 3'd3);
    start_pl   = (len_done && !oversize && !masked_eff) || mask_done;
    start_len  = (phase_q == PH_MASK) ? flen_q : new_len;
    start_zero = (start_len == 32'd0);
    is_end     = (({16'd0, idx_q} + 32'd1) == flen_q);
    start_next = start_zero ? ((op_q == OP_CLOSE) ? PH_CLOSED : PH_HDR0) : PH_PAYLOAD;
    len_next   = oversize ? PH_HDR0 : (masked_eff ? PH_MASK : start_next);
    unique case (idx_q[1:0])
      2'd0:    key_byte = mkey_q[31:24];
      2'd1:    key_byte = mkey_q[23:16];
      2'd2:    key_byte = mkey_q[15:8];
      default: key_byte = mkey_q[7:0];
    endcase
  end

  // next phase
  always_comb begin
    phase_d = phase_q;
    if (step_i) begin
      unique case (phase_q)
        PH_HDR0:    phase_d = PH_HDR1;
        PH_HDR1:    phase_d = ext_form ? PH_EXT : len_next;
        PH_EXT:     phase_d = len_done ? len_next : PH_EXT;
        PH_MASK:    phase_d = mask_done ? start_next : PH_MASK;
        PH_PAYLOAD: phase_d = is_end ? ((op_q == OP_CLOSE) ? PH_CLOSED : PH_HDR0)
                                     : PH_PAYLOAD;
        PH_CLOSED:  phase_d = PH_CLOSED;
        default:    phase_d = PH_HDR0;
      endcase
    end
  end

  // header fields, length, mask key and payload index
  always_comb begin
    final_d  = final_q;
    op_d     = op_q;
    masked_d = masked_q;
    long_d   = long_q;
    flen_d   = flen_q;
    hbc_d    = hbc_q;
    mkey_d   = mkey_q;
    idx_d    = idx_q;
    if (step_i) begin
      unique case (phase_q)
        PH_HDR0: begin
          final_d = byte_i[7];
          op_d    = byte_i[3:0];
        end
        PH_HDR1: begin
          masked_d = byte_i[7];
          long_d   = (len7 == LEN_EXT64);
          flen_d   = new_len;
          hbc_d    = 3'd0;
        end
        PH_EXT: begin
          flen_d = new_len;
          if (!len_done) begin
            hbc_d = hbc_q + 3'd1;
          end
        end
        PH_MASK: begin
          mkey_d = {mkey_q[23:0], byte_i};
          if (!mask_done) begin
            hbc_d = hbc_q + 3'd1;
          end
        end
        PH_PAYLOAD: idx_d = idx_q + 16'd1;
        default: ;
      endcase
      if (len_done && !oversize) begin
        mkey_d = 32'd0;
        hbc_d  = 3'd0;
      end
      if (start_pl) begin
        idx_d = 16'd0;
      end
    end
  end

  // results and message tracking
  always_comb begin
    res_valid_o = 1'b0;
    res_o.kind  = KIND_DISCARD;
    res_o.data  = 8'd0;
    res_o.last  = 1'b0;
    open_d      = open_q;
    drop_set    = 1'b0;
    open_eff    = open_q;
    if (step_i) begin
      if (oversize) begin
        res_valid_o = 1'b1;
        res_o.kind  = KIND_OVERSIZE;
        drop_set    = open_q;
        open_d      = 1'b0;
      end else if (start_pl) begin
        if (op_q == OP_BINARY) begin
          drop_set = open_q;
          open_eff = 1'b1;
        end
        open_d = open_eff;
        if (start_zero) begin
          unique case (op_q)
            OP_BINARY, OP_CONT: begin
              if (fin_ok(op_q, final_q, open_eff)) begin
                res_valid_o = 1'b1;
                res_o.kind  = KIND_EMPTY_END;
                res_o.last  = 1'b1;
                open_d      = 1'b0;
              end
            end
            OP_PING: begin
              res_valid_o = 1'b1;
              res_o.kind  = KIND_EMPTY_PONG;
              res_o.last  = 1'b1;
            end
            OP_CLOSE: begin
              res_valid_o = 1'b1;
              res_o.kind  = KIND_CLOSE;
              drop_set    = open_eff;
              open_d      = 1'b0;
            end
            default: ;
          endcase
        end
      end else if (phase_q == PH_PAYLOAD) begin
        res_valid_o = 1'b1;
        unique case (op_q)
          OP_BINARY, OP_CONT: begin
            if (open_q) begin
              res_o.kind = KIND_MSG;
              res_o.data = byte_i ^ key_byte;
              res_o.last = final_q && is_end;
              if (final_q && is_end) begin
                open_d = 1'b0;
              end
            end
          end
          OP_PING: begin
            res_o.kind = KIND_PONG;
            res_o.data = byte_i ^ key_byte;
            res_o.last = is_end;
          end
          OP_CLOSE: begin
            if (is_end) begin
              res_o.kind = KIND_CLOSE;
              drop_set   = open_q;
              open_d     = 1'b0;
            end
          end
          default: ;
        endcase
      end
    end
    res_o.dropped_before = drop_q || drop_set;
    drop_d = res_valid_o ? 1'b0 : (drop_q || drop_set);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q  <= PH_HDR0;
      hbc_q    <= 3'd0;
      final_q  <= 1'b0;
      op_q     <= 4'd0;
      masked_q <= 1'b0;
      long_q   <= 1'b0;
      flen_q   <= 32'd0;
      idx_q    <= 16'd0;
      mkey_q   <= 32'd0;
      open_q   <= 1'b0;
      drop_q   <= 1'b0;
    end else begin
      phase_q  <= phase_d;
      hbc_q    <= hbc_d;
      final_q  <= final_d;
      op_q     <= op_d;
      masked_q <= masked_d;
      long_q   <= long_d;
      flen_q   <= flen_d;
      idx_q    <= idx_d;
      mkey_q   <= mkey_d;
      open_q   <= open_d;
      drop_q   <= drop_d;
    end
  end

endmodule

`default_nettype wire

/* rtl/websocket_frame_deframer.sv */
// ----------------------------------------------------------------------------
// websocket_frame_deframer
// receive-side websocket frame parser with payload unmasking
// ----------------------------------------------------------------------------
// One received byte is taken per request on the input channel, and a new byte
// can be taken every clock cycle while the skid buffer is empty. Header bytes
// (first two header bytes, the 16-bit or 64-bit extended length, of which only
// the low 32 bits count, and the optional 4-byte mask key) give no result but
// for the oversize report on the length byte; payload bytes and the ends of
// empty frames give at most one result each. The parser state is updated in
// the cycle the byte is taken. Results sit in an output register backed by a
// one-entry skid buffer, so the input only stalls when both hold a request
// that the sink has not taken. Binary payload bytes and continuation payload
// bytes of an open message come out as message bytes with last marking the
// end of the message; ping payloads come out as pong bytes; a close frame
// reports close and from then on every byte is swallowed until reset. A frame
// longer than max_frame_len (reset value 8192) reports oversize and parsing
// restarts at the next byte. dropped_before flags that a partially delivered
// message was thrown away before this result. max_frame_len is written through
// the write enable; the user must do so only while the block is idle, which the block does not enforce.
`default_nettype none

module websocket_frame_deframer import wsdf_pkg::*; (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  // configuration
  input  wire logic        max_frame_len_we_i,
  input  wire logic [15:0] max_frame_len_i,
  // byte stream in
  input  wire logic        in_valid_i,
  output logic             in_ready_o,
  input  wire logic [7:0]  byte_in_i,
  // results out
  output logic             out_valid_o,
  input  wire logic        out_ready_i,
  output logic [2:0]       kind_o,
  output logic [7:0]       data_o,
  output logic             last_o,
  output logic             dropped_before_o
);

  logic [15:0] max_len_q;
  logic        step;
  logic        res_valid;
  result_t     res;

  // output register and skid stage
  logic        out_valid_q, out_valid_d;
  result_t     out_q, out_d;
  logic        skid_valid_q, skid_valid_d;
  result_t     skid_q, skid_d;

  // frame length limit register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      max_len_q <= MAX_FRAME_LEN_RST;
    end else if (max_frame_len_we_i) begin
      max_len_q <= max_frame_len_i;
    end
  end

  // a byte is taken whenever the skid stage is free
  assign in_ready_o = !skid_valid_q;
  assign step       = in_valid_i && in_ready_o;

  wsdf_parser u_parser (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .step_i          (step),
    .byte_i          (byte_in_i),
    .max_frame_len_i (max_len_q),
    .res_valid_o     (res_valid),
    .res_o           (res)
  );

  // result buffering: the output register refills from the skid stage first,
  // a fresh result goes to the skid stage only if the output register stays full
  always_comb begin
    out_valid_d  = out_valid_q;
    out_d        = out_q;
    skid_valid_d = skid_valid_q;
    skid_d       = skid_q;
    if (out_valid_q && out_ready_i) begin
      out_valid_d = 1'b0;
    end
    if (skid_valid_q && !out_valid_d) begin
      out_valid_d  = 1'b1;
      out_d        = skid_q;
      skid_valid_d = 1'b0;
    end
    if (res_valid) begin
      if (!out_valid_d) begin
        out_valid_d = 1'b1;
        out_d       = res;
      end else begin
        skid_valid_d = 1'b1;
        skid_d       = res;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q  <= 1'b0;
      skid_valid_q <= 1'b0;
    end else begin
      out_valid_q  <= out_valid_d;
      skid_valid_q <= skid_valid_d;
    end
  end

  // payload registers, no reset needed
  always_ff @(posedge clk_i) begin
    out_q  <= out_d;
    skid_q <= skid_d;
  end

  assign out_valid_o      = out_valid_q;
  assign kind_o           = out_q.kind;
  assign data_o           = out_q.data;
  assign last_o           = out_q.last;
  assign dropped_before_o = out_q.dropped_before;

  // skid stage only ever holds a request behind a full output register
  a_skid_behind_out: assert property (@(posedge clk_i) disable iff (!rst_ni)
    skid_valid_q |-> out_valid_q)
    else $error("skid stage full while output register empty");

  // only message and pong bytes carry data
  a_data_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && !(out_q.kind == KIND_MSG || out_q.kind == KIND_PONG))
      |-> (data_o == 8'd0))
    else $error("data set on a result without payload");

  // empty message end and empty pong always close their sequence
  a_empty_last: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && (out_q.kind == KIND_EMPTY_END || out_q.kind == KIND_EMPTY_PONG))
      |-> last_o)
    else $error("empty end without last");

  // discard, close and oversize never mark last
  a_no_last: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && (out_q.kind == KIND_DISCARD || out_q.kind == KIND_CLOSE ||
                     out_q.kind == KIND_OVERSIZE)) |-> !last_o)
    else $error("last set on a non-data result");

endmodule

`default_nettype wire
